>>> rtl/inverse_square_field_voxel_unit_assert.svh
// Assertion macros for the inverse-square field voxel unit.
// Expects signals named clock and reset in the including module.
`ifndef INVERSE_SQUARE_FIELD_VOXEL_UNIT_ASSERT_SVH
`define INVERSE_SQUARE_FIELD_VOXEL_UNIT_ASSERT_SVH

// Same-cycle implication, disabled in reset.
`define ISFV_ASSERT_NOW(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, disabled in reset.
`define ISFV_ASSERT_NEXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

>>> rtl/isfv_pkg.sv
// Shared constants for the inverse-square field voxel unit.
// No dependencies.
package isfv_pkg;

   localparam int DEF_MAX_POINTS = 256;
   localparam int DEF_MAX_DIM    = 1024;

   localparam int CSR_IDX_W  = 2;
   localparam int CSR_DATA_W = 11;
   localparam int DIM_REG_W  = 11;
   localparam int PC_REG_W   = 9;

   localparam logic [CSR_IDX_W-1:0] REG_DIM_X       = 2'd0;
   localparam logic [CSR_IDX_W-1:0] REG_DIM_Y       = 2'd1;
   localparam logic [CSR_IDX_W-1:0] REG_DIM_Z       = 2'd2;
   localparam logic [CSR_IDX_W-1:0] REG_POINT_COUNT = 2'd3;

   localparam logic [DIM_REG_W-1:0] DIM_RESET = 11'd64;

   localparam int COORD_W = 16;
   localparam int WT_W    = 16;
   localparam int VOX_W   = 10;
   localparam int WORLD_W = 27;   // mapped coordinate, signed
   localparam int MAG_W   = 27;   // |world - centre|
   localparam int D2_W    = 54;   // sum of three squares
   localparam int NUM_W   = 44;   // weight << 28
   localparam int MUL_W   = 32;
   localparam int SUM_W   = 32;
   localparam int IDX_W   = 30;
   localparam int Q_FRAC  = 28;
   localparam int MAP_SH  = 15;
   localparam int ONE_Q14 = 16384;

endpackage

>>> rtl/inverse_square_field_voxel_unit.sv
// Inverse-square point-source field, one voxel per query transaction.
// Depends on isfv_pkg and inverse_square_field_voxel_unit_assert.svh.
//
// Usage:
//  req_* channel: mode 0 writes a point source (centre, weight) into table
//  slot point_slot and produces no response. Mode 1
//  queries voxel (voxel_i, voxel_j, voxel_k); one response transaction on
//  rsp_* carries the saturating Q16.16 sum of weight / distance^2 over the
//  first point_count table entries, the voxel's linear index and a
//  saturation flag.
//  A query first maps the three axes on one shared restoring divider
//  (one quotient bit a cycle) and forms the linear index; then, for each
//  point, it fetches the entry, forms the squared distance on the shared
//  multiplier and divides the weight by it for the term.
//  The loop stops early once the sum saturates.
//  req_stall is high while a query is in progress; loads and the next query
//  are taken while an earlier response still waits in the output register.
//  If rsp_stall holds the output register, a finished query waits for it.
//  csr_* writes the dims and point_count; write only while idle.
//  Reset clears control state and restores the register defaults; the
//  point table is undefined until loaded.
module inverse_square_field_voxel_unit #(
   parameter int MAX_POINTS = isfv_pkg::DEF_MAX_POINTS,
   parameter int MAX_DIM    = isfv_pkg::DEF_MAX_DIM
) (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               csr_write,
   input  logic [isfv_pkg::CSR_IDX_W-1:0]     csr_index,
   input  logic [isfv_pkg::CSR_DATA_W-1:0]    csr_data,
   input  logic                               req_valid,
   output logic                               req_stall,
   input  logic                               req_mode,
   input  logic [7:0]                         req_point_slot,
   input  logic signed [isfv_pkg::COORD_W-1:0] req_center_x,
   input  logic signed [isfv_pkg::COORD_W-1:0] req_center_y,
   input  logic signed [isfv_pkg::COORD_W-1:0] req_center_z,
   input  logic [isfv_pkg::WT_W-1:0]          req_point_weight,
   input  logic [isfv_pkg::VOX_W-1:0]         req_voxel_i,
   input  logic [isfv_pkg::VOX_W-1:0]         req_voxel_j,
   input  logic [isfv_pkg::VOX_W-1:0]         req_voxel_k,
   output logic                               rsp_valid,
   input  logic                               rsp_stall,
   output logic [isfv_pkg::SUM_W-1:0]         rsp_field_value,
   output logic [isfv_pkg::IDX_W-1:0]         rsp_linear_index,
   output logic                               rsp_saturated
);
   import isfv_pkg::*;

   localparam int AW   = (MAX_POINTS > 1) ? $clog2(MAX_POINTS) : 1;
   localparam int CW   = $clog2(MAX_POINTS + 1);
   localparam int PCW  = (CW > PC_REG_W) ? CW : PC_REG_W;
   localparam int DIMW = $clog2(MAX_DIM + 1);
   localparam int EW   = (DIMW > DIM_REG_W) ? DIMW : DIM_REG_W;
   localparam int REMW = D2_W + 1;
   localparam int DCW  = $clog2(NUM_W + 1);
   localparam int ENT_W = 3 * COORD_W + WT_W;

   typedef enum logic [3:0] {
      S_IDLE, S_MAP_GO, S_MAP_DIV, S_IDX_A, S_IDX_B, S_IDX_C, S_IDX_D,
      S_PT, S_SQX, S_SQY, S_SQZ, S_SQE, S_DIV_GO, S_DIV, S_DONE
   } state_type;

   // configuration
   logic [DIM_REG_W-1:0] dim_x_ff, dim_y_ff, dim_z_ff;
   logic [PC_REG_W-1:0]  pc_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         dim_x_ff <= DIM_RESET;
         dim_y_ff <= DIM_RESET;
         dim_z_ff <= DIM_RESET;
         pc_ff    <= '0;
      end else if (csr_write) begin
         case (csr_index)
            REG_DIM_X:       dim_x_ff <= csr_data;
            REG_DIM_Y:       dim_y_ff <= csr_data;
            REG_DIM_Z:       dim_z_ff <= csr_data;
            REG_POINT_COUNT: pc_ff    <= csr_data[PC_REG_W-1:0];
            default: ;
         endcase
      end
   end

   function automatic logic [DIMW-1:0] eff_dim(input logic [DIM_REG_W-1:0] d);
      logic [EW-1:0] w;
      w = EW'(d);
      if (w < EW'(2))
         w = EW'(2);
      else if (w > EW'(MAX_DIM))
         w = EW'(MAX_DIM);
      return w[DIMW-1:0];
   endfunction

   // point table
   logic [ENT_W-1:0] table_mem [MAX_POINTS];
   logic [ENT_W-1:0] rd_ff;
   logic [CW-1:0]    p_ff;
   logic             req_acc;

   assign req_acc = req_valid && !req_stall;

   always_ff @(posedge clock) begin
      if (req_acc && !req_mode && (32'(req_point_slot) < MAX_POINTS))
         table_mem[AW'(req_point_slot)] <= {req_center_x, req_center_y, req_center_z,
                                           req_point_weight};
      rd_ff <= table_mem[p_ff[AW-1:0]];
   end

   // sequencer state
   state_type            state_ff;
   logic [1:0]           axis_ff;
   logic [VOX_W-1:0]     vi_ff, vj_ff, vk_ff;
   logic [DIMW-1:0]      dx_ff, dy_ff, dz_ff;
   logic [CW-1:0]        n_ff;
   logic signed [WORLD_W-1:0] wx_ff, wy_ff, wz_ff;
   logic [IDX_W-1:0]     idx_ff;
   logic [D2_W-1:0]      d2_ff;
   logic [SUM_W-1:0]     sum_ff;
   logic                 sat_ff;
   logic [2*MUL_W-1:0]   mul_ff;
   logic [D2_W-1:0]      div_rem_ff, div_den_ff;
   logic [NUM_W-1:0]     div_quo_ff;
   logic [DCW-1:0]       div_cnt_ff;
   logic                 out_valid_ff, out_sat_ff;
   logic [SUM_W-1:0]     out_val_ff;
   logic [IDX_W-1:0]     out_idx_ff;

   // shared multiplier operands
   logic [MUL_W-1:0] mul_a, mul_b;
   logic signed [WORLD_W-1:0] diff;
   logic [MAG_W-1:0] mag;
   logic signed [COORD_W-1:0] ent_cx, ent_cy, ent_cz;
   logic [WT_W-1:0]  ent_wt;

   assign {ent_cx, ent_cy, ent_cz, ent_wt} = rd_ff;

   always_comb begin
      case (state_ff)
         S_SQX:   diff = wx_ff - WORLD_W'(ent_cx);
         S_SQY:   diff = wy_ff - WORLD_W'(ent_cy);
         default: diff = wz_ff - WORLD_W'(ent_cz);
      endcase
      mag = diff[WORLD_W-1] ? MAG_W'(-diff) : MAG_W'(diff);
      case (state_ff)
         S_IDX_A: begin
            mul_a = MUL_W'(dx_ff);
            mul_b = MUL_W'(dy_ff);
         end
         S_IDX_B: begin
            mul_a = MUL_W'(mul_ff[IDX_W-1:0]);
            mul_b = MUL_W'(vk_ff);
         end
         S_IDX_C: begin
            mul_a = MUL_W'(vj_ff);
            mul_b = MUL_W'(dx_ff);
         end
         default: begin
            mul_a = MUL_W'(mag);
            mul_b = MUL_W'(mag);
         end
      endcase
   end

   always_ff @(posedge clock)
      mul_ff <= mul_a * mul_b;

   // shared restoring divider step
   logic [REMW-1:0] trial;
   logic            qbit;
   logic [REMW-1:0] trial_sub;

   assign trial     = {div_rem_ff, div_quo_ff[NUM_W-1]};
   assign qbit      = (trial >= REMW'(div_den_ff));
   assign trial_sub = trial - REMW'(div_den_ff);

   // mapping inputs for the current axis
   logic [VOX_W-1:0] map_v;
   logic [DIMW-1:0]  map_dim, map_den;
   logic [NUM_W-1:0] map_num;
   logic signed [WORLD_W-1:0] map_w;
   logic [SUM_W:0]   sum_add;
   logic [PCW-1:0]   pc_w;

   always_comb begin
      case (axis_ff)
         2'd0: begin
            map_v   = vi_ff;
            map_dim = dx_ff;
         end
         2'd1: begin
            map_v   = vj_ff;
            map_dim = dy_ff;
         end
         default: begin
            map_v   = vk_ff;
            map_dim = dz_ff;
         end
      endcase
      map_den = map_dim - DIMW'(1);
      map_num = (NUM_W'(map_v) << MAP_SH) + NUM_W'(map_den >> 1);
      map_w   = WORLD_W'(div_quo_ff[WORLD_W-2:0]) - WORLD_W'(ONE_Q14);
      sum_add = {1'b0, sum_ff} + {1'b0, div_quo_ff[SUM_W-1:0]};
      pc_w    = PCW'(pc_ff);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         out_valid_ff <= 1'b0;
         div_cnt_ff   <= '0;
         sat_ff       <= 1'b0;
      end else begin
         // a finished query reloads the output register itself in S_DONE
         if (out_valid_ff && !rsp_stall && state_ff != S_DONE)
            out_valid_ff <= 1'b0;
         case (state_ff)
            S_IDLE: begin
               if (req_acc && req_mode) begin
                  vi_ff   <= req_voxel_i;
                  vj_ff   <= req_voxel_j;
                  vk_ff   <= req_voxel_k;
                  dx_ff   <= eff_dim(dim_x_ff);
                  dy_ff   <= eff_dim(dim_y_ff);
                  dz_ff   <= eff_dim(dim_z_ff);
                  n_ff    <= (pc_w > PCW'(MAX_POINTS)) ? CW'(MAX_POINTS) : CW'(pc_w);
                  axis_ff <= 2'd0;
                  state_ff <= S_MAP_GO;
               end
            end
            S_MAP_GO: begin
               div_rem_ff <= '0;
               div_quo_ff <= map_num;
               div_den_ff <= D2_W'(map_den);
               div_cnt_ff <= DCW'(NUM_W);
               state_ff   <= S_MAP_DIV;
            end
            S_MAP_DIV: begin
               if (div_cnt_ff != '0) begin
                  div_rem_ff <= qbit ? trial_sub[D2_W-1:0] : trial[D2_W-1:0];
                  div_quo_ff <= {div_quo_ff[NUM_W-2:0], qbit};
                  div_cnt_ff <= div_cnt_ff - DCW'(1);
               end else begin
                  case (axis_ff)
                     2'd0:    wx_ff <= map_w;
                     2'd1:    wy_ff <= map_w;
                     default: wz_ff <= map_w;
                  endcase
                  axis_ff  <= axis_ff + 2'd1;
                  state_ff <= (axis_ff == 2'd2) ? S_IDX_A : S_MAP_GO;
               end
            end
            S_IDX_A: state_ff <= S_IDX_B;
            S_IDX_B: state_ff <= S_IDX_C;
            S_IDX_C: begin
               idx_ff   <= mul_ff[IDX_W-1:0];
               state_ff <= S_IDX_D;
            end
            S_IDX_D: begin
               idx_ff   <= idx_ff + mul_ff[IDX_W-1:0] + IDX_W'(vi_ff);
               p_ff     <= '0;
               sum_ff   <= '0;
               sat_ff   <= 1'b0;
               state_ff <= S_PT;
            end
            S_PT: begin
               // table read of entry p lands in rd_ff next cycle
               state_ff <= (sat_ff || p_ff == n_ff) ? S_DONE : S_SQX;
            end
            S_SQX: state_ff <= S_SQY;
            S_SQY: begin
               d2_ff    <= D2_W'(mul_ff);
               state_ff <= S_SQZ;
            end
            S_SQZ: begin
               d2_ff    <= d2_ff + D2_W'(mul_ff);
               state_ff <= S_SQE;
            end
            S_SQE: begin
               d2_ff    <= d2_ff + D2_W'(mul_ff);
               state_ff <= S_DIV_GO;
            end
            S_DIV_GO: begin
               if (d2_ff == '0) begin
                  // coincident point: the term is unbounded
                  sat_ff   <= 1'b1;
                  state_ff <= S_PT;
               end else begin
                  div_rem_ff <= '0;
                  div_quo_ff <= {ent_wt, Q_FRAC'(0)};
                  div_den_ff <= d2_ff;
                  div_cnt_ff <= DCW'(NUM_W);
                  state_ff   <= S_DIV;
               end
            end
            S_DIV: begin
               if (div_cnt_ff != '0) begin
                  div_rem_ff <= qbit ? trial_sub[D2_W-1:0] : trial[D2_W-1:0];
                  div_quo_ff <= {div_quo_ff[NUM_W-2:0], qbit};
                  div_cnt_ff <= div_cnt_ff - DCW'(1);
               end else begin
                  if (div_quo_ff[NUM_W-1:SUM_W] != '0 || sum_add[SUM_W])
                     sat_ff <= 1'b1;
                  sum_ff   <= sum_add[SUM_W-1:0];
                  p_ff     <= p_ff + CW'(1);
                  state_ff <= S_PT;
               end
            end
            S_DONE: begin
               if (!out_valid_ff || !rsp_stall) begin
                  out_valid_ff <= 1'b1;
                  out_val_ff   <= sat_ff ? '1 : sum_ff;
                  out_sat_ff   <= sat_ff;
                  out_idx_ff   <= idx_ff;
                  state_ff     <= S_IDLE;
               end
            end
            default: state_ff <= S_IDLE;
         endcase
      end
   end

   assign req_stall        = (state_ff != S_IDLE);
   assign rsp_valid        = out_valid_ff;
   assign rsp_field_value  = out_val_ff;
   assign rsp_linear_index = out_idx_ff;
   assign rsp_saturated    = out_sat_ff;

`include "inverse_square_field_voxel_unit_assert.svh"

   `ISFV_ASSERT_NOW(a_sat_all_ones, rsp_valid && rsp_saturated, rsp_field_value == '1, "saturated response without full-scale value")
   `ISFV_ASSERT_NEXT(a_query_busy, req_acc && req_mode, req_stall, "query accepted but unit not busy")
   `ISFV_ASSERT_NOW(a_div_count, 1'b1, div_cnt_ff <= DCW'(NUM_W), "divider step count out of range")
   `ISFV_ASSERT_NEXT(a_sat_ends, state_ff == S_PT && sat_ff, state_ff == S_DONE, "point loop continued after saturation")

endmodule
